### rtl/ifq_pkg.sv
// Shared types and constants for the indexed FIFO queue.
`default_nettype none

package ifq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = 4;
   localparam int COUNT_W    = 5;

   typedef enum logic [2:0] {
      CMD_APPEND = 3'd0,
      CMD_POP    = 3'd1,
      CMD_READ   = 3'd2,
      CMD_REMOVE = 3'd3,
      CMD_CLEAR  = 3'd4,
      CMD_COUNT  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type                 command;
      logic [IDX_W-1:0]        position;
      logic [DATA_WIDTH-1:0]   write_data;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [DATA_WIDTH-1:0]   read_data;
      logic [COUNT_W-1:0]      occupancy;
   } rsp_type;

   // Per-cell control: load from the write port or take the neighbor's word
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

### rtl/ifq_cell.sv
// One storage cell of the shifting queue row.
`default_nettype none

module ifq_cell
   import ifq_pkg::*;
(
   input  wire logic                  clock,
   input  wire cell_ctrl_type         ctrl,
   input  wire logic [DATA_WIDTH-1:0] write_data,
   input  wire logic [DATA_WIDTH-1:0] next_data,
   output logic      [DATA_WIDTH-1:0] data
);

   logic [DATA_WIDTH-1:0] entry_ff;

   // Load a new tail word, or shift toward the head
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         entry_ff <= write_data;
      end else if (ctrl.shift) begin
         entry_ff <= next_data;
      end
   end

   assign data = entry_ff;

endmodule

`default_nettype wire

### rtl/indexed_fifo_queue.sv
// Indexed FIFO queue: top level with cell row, command decode and result register.
//
// Usage:
//   Commands arrive on the req_ channel (req_valid, req_stall, req_item) and
//   each produces exactly one result beat on the rsp_ channel (rsp_valid,
//   rsp_stall, rsp_item) carrying status, read data and occupancy.
//   A command is executed in the cycle it is accepted; its result is registered
//   and appears on rsp_item in the next cycle. One command is taken per cycle
//   while req_stall is low, so throughput is one beat per cycle then. Pop and
//   remove move every later cell one place toward the head together, just as
//   an append loads the tail cell when the command is accepted.
//   The result register decouples the sides: a new command is accepted while
//   a result is waiting, as long as that result is taken in the same cycle.
//   When the receiver stalls with a result held, req_stall is raised and the
//   held result stays unchanged until taken.
//   Reset (synchronous, active high) empties the queue and drops any pending
//   result; stored words are not cleared, they become unreachable.
`default_nettype none

module indexed_fifo_queue
   import ifq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_item,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_item
);

   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_item_ff, rsp_item_in;
   logic                  accept;
   logic                  do_append, do_shift;
   logic [IDX_W-1:0]      shift_base;
   logic                  pos_ok;
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   cell_ctrl_type         cell_ctrl [DEPTH];

   // Handshake: stall only while a held result is itself stalled
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign pos_ok    = {1'b0, req_item.position} < count_ff;

   // Command decode and result formation
   always_comb begin
      count_in            = count_ff;
      rsp_item_in.status    = ST_OK;
      rsp_item_in.read_data = '0;
      do_append           = 1'b0;
      do_shift            = 1'b0;
      shift_base          = req_item.position;
      case (req_item.command)
         CMD_APPEND: begin
            if (count_ff == COUNT_W'(DEPTH)) begin
               rsp_item_in.status = ST_FULL;
            end else begin
               do_append = 1'b1;
               count_in  = count_ff + COUNT_W'(1);
            end
         end
         CMD_POP: begin
            shift_base = '0;
            if (count_ff == '0) begin
               rsp_item_in.status = ST_RANGE;
            end else begin
               rsp_item_in.read_data = cell_data[0];
               do_shift              = 1'b1;
               count_in              = count_ff - COUNT_W'(1);
            end
         end
         CMD_READ: begin
            if (!pos_ok) begin
               rsp_item_in.status = ST_RANGE;
            end else begin
               rsp_item_in.read_data = cell_data[req_item.position];
            end
         end
         CMD_REMOVE: begin
            if (!pos_ok) begin
               rsp_item_in.status = ST_RANGE;
            end else begin
               do_shift = 1'b1;
               count_in = count_ff - COUNT_W'(1);
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
      rsp_item_in.occupancy = count_in;
      rsp_valid_in          = accept | (rsp_valid_ff & rsp_stall);
   end

   // Cell row: each cell below the last takes its upper neighbor's word on a shift; the last keeps its own
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [DATA_WIDTH-1:0] next_data;

      if (k == DEPTH - 1) begin : g_last
         assign next_data = cell_data[k];
      end else begin : g_mid
         assign next_data = cell_data[k+1];
      end

      assign cell_ctrl[k].load  = accept & do_append & (count_ff == COUNT_W'(k));
      assign cell_ctrl[k].shift = accept & do_shift & (IDX_W'(k) >= shift_base);

      ifq_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[k]),
         .write_data (req_item.write_data),
         .next_data  (next_data),
         .data       (cell_data[k])
      );
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("occupancy beyond capacity");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      accept && req_item.command == CMD_CLEAR |=> count_ff == '0 && rsp_item.occupancy == '0)
      else $error("clear did not empty the queue");

   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      accept && req_item.command == CMD_POP && count_ff != '0
      |=> count_ff == $past(count_ff) - COUNT_W'(1) && rsp_item.status == ST_OK)
      else $error("pop did not shrink the queue");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("held result dropped");
`endif

endmodule

`default_nettype wire
